// File: rtl/encoder_counted_turn_sequencer_defines.svh
// Assertion macros shared by the turn sequencer RTL.
// Each expects clk and rst_n in the including module's scope.
`ifndef ENCODER_COUNTED_TURN_SEQUENCER_DEFINES_SVH
`define ENCODER_COUNTED_TURN_SEQUENCER_DEFINES_SVH

// Same-cycle implication.
`define ECTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ECTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ects_pkg.sv
// Shared widths, codes, reset values and structs for the turn sequencer.
// No dependencies.
package ects_pkg;

  localparam int AGE_W     = 8;
  localparam int COUNT_W   = 16;
  localparam int PAUSE_W   = 24;
  localparam int PATTERN_W = 4;
  localparam int DRIVE_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam int SEQ_STEPS_DEF = 4;

  localparam logic [AGE_W-1:0]     AGE_MAX   = '1;
  localparam logic [COUNT_W-1:0]   COUNT_MAX = '1;

  localparam logic [AGE_W-1:0]     DEBOUNCE_RST = 8'd2;
  localparam logic [COUNT_W-1:0]   TARGET_RST   = 16'd21;
  localparam logic [PAUSE_W-1:0]   PAUSE_RST    = 24'd10000;
  localparam logic [PATTERN_W-1:0] PATTERN_RST  = 4'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN  = 2'd3;

  localparam logic [DRIVE_W-1:0] DRIVE_STOP = 2'd0;
  localparam logic [DRIVE_W-1:0] DRIVE_FWD  = 2'd1;
  localparam logic [DRIVE_W-1:0] DRIVE_REV  = 2'd2;

  typedef enum logic {
    PH_TURN,
    PH_PAUSE
  } phase_t;

  typedef struct packed {
    logic en;   // item transfer this cycle
    logic clr;  // next turn starts: count restarts from zero
    logic hit;  // encoder edge seen
  } wheel_ctl_t;

  typedef struct packed {
    logic               pulse;  // edge accepted as a pulse
    logic [COUNT_W-1:0] count;  // count after this tick
  } wheel_stat_t;

endpackage

// File: rtl/ects_wheel.sv
// One wheel's debounce age and saturating pulse counter.
// Depends on ects_pkg.
module ects_wheel (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ects_pkg::wheel_ctl_t          ctl,
  input  logic [ects_pkg::AGE_W-1:0]    debounce,
  output ects_pkg::wheel_stat_t         stat
);
  import ects_pkg::*;

  logic [AGE_W-1:0]   age_r, age_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt, count_base;
  logic               pulse;

  always_comb begin
    count_base = ctl.clr ? '0 : count_r;
    pulse      = ctl.hit && (age_r >= debounce);
    count_nxt  = count_base;
    if (pulse && (count_base != COUNT_MAX)) begin
      count_nxt = count_base + COUNT_W'(1);
    end
    if (pulse) begin
      age_nxt = AGE_W'(1);
    end else if (age_r != AGE_MAX) begin
      age_nxt = age_r + AGE_W'(1);
    end else begin
      age_nxt = age_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r   <= '0;
      count_r <= '0;
    end else if (ctl.en) begin
      age_r   <= age_nxt;
      count_r <= count_nxt;
    end
  end

  assign stat.pulse = pulse;
  assign stat.count = count_nxt;

endmodule

// File: rtl/encoder_counted_turn_sequencer.sv
// Channel  | handshake            | payload
// in       | in_valid / in_ready  | in_left_edge, in_right_edge
// out      | out_valid / out_ready| drives, turning, turn_done, pulse counts
// cfg      | cfg_we               | cfg_index, cfg_wdata
// One tick per cycle while in_ready is high: the state update and result
// are computed in one pass from the state registers and land in the output
// register the same edge; in_ready stays high while it is empty or draining.
// Synchronous active-low reset; the first turn is running right after reset.
// Depends on ects_pkg, ects_wheel and the defines header.
`include "encoder_counted_turn_sequencer_defines.svh"

module encoder_counted_turn_sequencer #(
  parameter int SEQUENCE_STEPS = ects_pkg::SEQ_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_left_edge,
  input  logic                              in_right_edge,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ects_pkg::DRIVE_W-1:0]      out_left_drive,
  output logic [ects_pkg::DRIVE_W-1:0]      out_right_drive,
  output logic                              out_turning,
  output logic                              out_turn_done,
  output logic [ects_pkg::COUNT_W-1:0]      out_left_pulses,
  output logic [ects_pkg::COUNT_W-1:0]      out_right_pulses,
  input  logic                              cfg_we,
  input  logic [ects_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ects_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ects_pkg::*;

  localparam int STEP_W = (SEQUENCE_STEPS > 1) ? $clog2(SEQUENCE_STEPS) : 1;

  // configuration
  logic [AGE_W-1:0]     debounce_r;
  logic [COUNT_W-1:0]   target_r;
  logic [PAUSE_W-1:0]   pause_ticks_r;
  logic [PATTERN_W-1:0] pattern_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r    <= DEBOUNCE_RST;
      target_r      <= TARGET_RST;
      pause_ticks_r <= PAUSE_RST;
      pattern_r     <= PATTERN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: debounce_r    <= cfg_wdata[AGE_W-1:0];
        CFG_TARGET:   target_r      <= cfg_wdata[COUNT_W-1:0];
        CFG_PAUSE:    pause_ticks_r <= cfg_wdata[PAUSE_W-1:0];
        CFG_PATTERN:  pattern_r     <= cfg_wdata[PATTERN_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic in_fire;
  logic out_valid_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // sequencer state
  phase_t             phase_r, phase_nxt;
  logic [PAUSE_W-1:0] pause_left_r, pause_left_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;

  logic        restart;
  logic        still_pausing;
  logic        reached;
  logic [COUNT_W:0] pulse_sum;
  logic [PATTERN_W-1:0] pat_sh;
  logic        right_turn;

  wheel_ctl_t  l_ctl, r_ctl;
  wheel_stat_t l_stat, r_stat;

  assign restart       = (phase_r == PH_PAUSE) && (pause_left_r == '0);
  assign still_pausing = (phase_r == PH_PAUSE) && !restart;

  assign l_ctl = '{en: in_fire, clr: restart, hit: in_left_edge};
  assign r_ctl = '{en: in_fire, clr: restart, hit: in_right_edge};

  ects_wheel u_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (l_ctl),
    .debounce (debounce_r),
    .stat     (l_stat)
  );

  ects_wheel u_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (r_ctl),
    .debounce (debounce_r),
    .stat     (r_stat)
  );

  assign pulse_sum  = {1'b0, l_stat.count} + {1'b0, r_stat.count};
  assign reached    = pulse_sum[COUNT_W:1] >= target_r;
  assign pat_sh     = pattern_r >> step_r;
  assign right_turn = pat_sh[0];

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    pause_left_nxt = pause_left_r;
    step_nxt       = step_r;
    unique case (phase_r)
      PH_PAUSE: begin
        if (!restart) begin
          pause_left_nxt = pause_left_r - PAUSE_W'(1);
        end else begin
          phase_nxt = PH_TURN;
        end
      end
      PH_TURN: ;
      default: ;
    endcase
    if (!still_pausing && reached) begin
      phase_nxt      = PH_PAUSE;
      pause_left_nxt = pause_ticks_r;
      step_nxt       = (step_r == STEP_W'(SEQUENCE_STEPS - 1)) ? '0
                                                               : step_r + STEP_W'(1);
    end
  end

  // result
  logic [DRIVE_W-1:0] left_drive, right_drive;
  logic               turning, turn_done;

  always_comb begin
    left_drive  = DRIVE_STOP;
    right_drive = DRIVE_STOP;
    turning     = 1'b0;
    turn_done   = 1'b0;
    if (!still_pausing) begin
      if (reached) begin
        turn_done = 1'b1;
      end else begin
        turning     = 1'b1;
        left_drive  = right_turn ? DRIVE_FWD : DRIVE_REV;
        right_drive = right_turn ? DRIVE_REV : DRIVE_FWD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TURN;
      pause_left_r <= '0;
      step_r       <= '0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      pause_left_r <= pause_left_nxt;
      step_r       <= step_nxt;
    end
  end

  // output register
  logic [DRIVE_W-1:0] left_drive_r, right_drive_r;
  logic               turning_r, turn_done_r;
  logic [COUNT_W-1:0] left_pulses_r, right_pulses_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      left_drive_r   <= left_drive;
      right_drive_r  <= right_drive;
      turning_r      <= turning;
      turn_done_r    <= turn_done;
      left_pulses_r  <= l_stat.count;
      right_pulses_r <= r_stat.count;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_drive   = left_drive_r;
  assign out_right_drive  = right_drive_r;
  assign out_turning      = turning_r;
  assign out_turn_done    = turn_done_r;
  assign out_left_pulses  = left_pulses_r;
  assign out_right_pulses = right_pulses_r;

  `ECTS_ASSERT_IMP(a_turn_excl, out_valid_r, !(turning_r && turn_done_r),
    "turning and turn_done both set")
  `ECTS_ASSERT_IMP(a_stop_drive, out_valid_r && !turning_r,
    (left_drive_r == DRIVE_STOP) && (right_drive_r == DRIVE_STOP),
    "motor driven while not turning")
  `ECTS_ASSERT_IMP(a_spin_drive, out_valid_r && turning_r,
    (left_drive_r != DRIVE_STOP) && (left_drive_r != right_drive_r),
    "turn drive is not a spin")
  `ECTS_ASSERT_NXT(a_done_pause, in_fire && turn_done, phase_r == PH_PAUSE,
    "completed turn did not enter pause")
  `ECTS_ASSERT_NXT(a_pause_dec, in_fire && still_pausing,
    pause_left_r == $past(pause_left_r) - PAUSE_W'(1),
    "pause counter did not step down")
  `ECTS_ASSERT_IMP(a_pulse_cnt, in_fire && (l_stat.pulse || r_stat.pulse),
    (pulse_sum != '0), "accepted pulse left counts at zero")

endmodule
